// ===== hdl/rbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbrm_pkg
// Shared types, codes and constants of the receive buffer ring manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbrm_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  RESET_START_PAGE = 8'h46;
  localparam logic [7:0]  RESET_STOP_PAGE  = 8'hAA;
  localparam logic [7:0]  RESET_READ_PAGE  = RESET_START_PAGE + 8'd1;
  localparam logic [15:0] HEADER_BYTES     = 16'd4;

  localparam logic [1:0] OP_POST   = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_POSTED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELIVERED = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic CFG_IDX_START = 1'b0;
  localparam logic CFG_IDX_STOP  = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] buffer_size;
    logic [15:0] length;
    logic [7:0]  next_page;
  } rbrm_entry_t;

  typedef struct packed {
    logic        valid;
    rbrm_entry_t entry;
  } rbrm_qhead_t;

  typedef struct packed {
    logic [7:0] start_page;
    logic [7:0] stop_page;
  } rbrm_cfg_t;

endpackage

// ===== hdl/rbrm_if.sv =====
// ----------------------------------------------------------------------------
// rbrm_if
// Valid/ready channel interfaces for packet items and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] buffer_size;
  logic [15:0] packet_count;
  logic [7:0]  next_page;

  modport source (output valid, operation, buffer_size, packet_count, next_page,
                  input ready);
  modport sink (input valid, operation, buffer_size, packet_count, next_page,
                output ready);
endinterface

interface rbrm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [15:0] length;
  logic [7:0]  boundary;
  logic [7:0]  read_page;

  modport source (output valid, status, slot, length, boundary, read_page,
                  input ready);
  modport sink (input valid, status, slot, length, boundary, read_page,
                output ready);
endinterface

// ===== hdl/rbrm_front.sv =====
// ----------------------------------------------------------------------------
// rbrm_front
// Accepts input beats, drops unused operation codes, precomputes the payload
// length and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbrm_front import rbrm_pkg::*; (
  rbrm_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        q_push,
  output rbrm_entry_t q_entry
);

  logic known_op;

  assign in_ch.ready = !q_full;

  assign known_op = (in_ch.operation == OP_POST) || (in_ch.operation == OP_PACKET) ||
                    (in_ch.operation == OP_CLEAR);

  assign q_push = in_ch.valid && in_ch.ready && known_op;

  assign q_entry.op          = in_ch.operation;
  assign q_entry.buffer_size = in_ch.buffer_size;
  assign q_entry.length      = in_ch.packet_count - HEADER_BYTES;
  assign q_entry.next_page   = in_ch.next_page;

endmodule

// ===== hdl/rbrm_queue.sv =====
// ----------------------------------------------------------------------------
// rbrm_queue
// Short FIFO that decouples the front classifier from the ring back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbrm_queue import rbrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rbrm_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output rbrm_qhead_t head
);

  rbrm_entry_t       slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/rbrm_back.sv =====
// ----------------------------------------------------------------------------
// rbrm_back
// Executes queued items against the buffer ring: slot pointers, capacity
// memory, read page and boundary, and holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbrm_back import rbrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rbrm_cfg_t   cfg,
  input  rbrm_qhead_t head,
  output logic        pop,
  rbrm_out_if.source  out_ch
);

  logic [15:0]       cap_mem [SLOT_COUNT];
  logic [15:0]       cap_rd_r;

  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;
  logic              has_posted_r, has_posted_nxt;
  logic [7:0]        page_r, page_nxt;
  logic              out_valid_r;

  logic [2:0]        status_r;
  logic [5:0]        slot_r;
  logic [15:0]       length_r;
  logic [7:0]        boundary_r;
  logic [7:0]        read_page_r;
  logic              check_r;

  logic              take;
  logic              mem_we;
  logic              rd_en;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [15:0]       res_length;
  logic [7:0]        bnd_dec;
  logic [7:0]        res_boundary;
  logic [SLOT_W-1:0] free_inc;
  logic [SLOT_W-1:0] oldest_inc;

  assign take = head.valid && (!out_valid_r || out_ch.ready);
  assign pop  = take;

  assign free_inc   = (free_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : SLOT_W'(free_r + 1'b1);
  assign oldest_inc = (oldest_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : SLOT_W'(oldest_r + 1'b1);

  always_comb begin
    oldest_nxt     = oldest_r;
    free_nxt       = free_r;
    has_posted_nxt = has_posted_r;
    page_nxt       = page_r;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    res_status     = ST_POSTED;
    res_slot       = '0;
    res_length     = '0;
    case (head.entry.op)
      OP_POST: begin
        res_slot = free_r;
        if (has_posted_r && (free_r == oldest_r)) begin
          res_status = ST_FULL;
        end else begin
          mem_we   = take;
          free_nxt = free_inc;
          if (!has_posted_r) begin
            oldest_nxt     = free_r;
            has_posted_nxt = 1'b1;
          end
        end
      end
      OP_PACKET: begin
        page_nxt = head.entry.next_page;
        if (!has_posted_r) begin
          res_status = ST_DROPPED;
        end else begin
          rd_en          = 1'b1;
          res_status     = ST_DELIVERED;
          res_slot       = oldest_r;
          res_length     = head.entry.length;
          oldest_nxt     = oldest_inc;
          has_posted_nxt = (oldest_inc != free_r);
        end
      end
      OP_CLEAR: begin
        res_status     = ST_CLEARED;
        has_posted_nxt = 1'b0;
        free_nxt       = '0;
        oldest_nxt     = '0;
      end
      default: begin
        res_status = ST_POSTED;
      end
    endcase
  end

  assign bnd_dec      = page_nxt - 8'd1;
  assign res_boundary = (bnd_dec < cfg.start_page) ? (cfg.stop_page - 8'd1) : bnd_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r     <= '0;
      free_r       <= '0;
      has_posted_r <= 1'b0;
      page_r       <= RESET_READ_PAGE;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        oldest_r     <= oldest_nxt;
        free_r       <= free_nxt;
        has_posted_r <= has_posted_nxt;
        page_r       <= page_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r    <= res_status;
      slot_r      <= 6'(res_slot);
      length_r    <= res_length;
      boundary_r  <= res_boundary;
      read_page_r <= page_nxt;
      check_r     <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cap_mem[free_r] <= head.entry.buffer_size;
    end
    if (take && rd_en) begin
      cap_rd_r <= cap_mem[oldest_r];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = check_r ? ((length_r > cap_rd_r) ? ST_TOO_LARGE : ST_DELIVERED)
                                    : status_r;
  assign out_ch.slot      = slot_r;
  assign out_ch.length    = length_r;
  assign out_ch.boundary  = boundary_r;
  assign out_ch.read_page = read_page_r;

`ifndef SYNTHESIS
  a_empty_pointers_meet: assert property (@(posedge clk) disable iff (!rst_n)
    !has_posted_r |-> (oldest_r == free_r))
    else $error("Empty ring with oldest and free slots apart.");

  a_clear_resets_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (head.entry.op == OP_CLEAR)) |=>
      (!has_posted_r && (free_r == '0) && (oldest_r == '0)))
    else $error("Clear did not empty the ring.");

  a_full_keeps_free: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (head.entry.op == OP_POST) && has_posted_r && (free_r == oldest_r)) |=>
      ($stable(free_r) && $stable(oldest_r) && has_posted_r))
    else $error("Post into a full ring moved the slot pointers.");

  a_held_beat_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !take)
    else $error("Result beat overwritten while stalled.");
`endif

endmodule

// ===== hdl/rx_buffer_ring_manager.sv =====
// ----------------------------------------------------------------------------
// rx_buffer_ring_manager
// Receive buffer ring manager: host buffer slots, read page and boundary.
// ----------------------------------------------------------------------------
// Items enter on in_ch: post a host buffer, report an arrived packet header,
// or clear the buffer ring. Each accepted item with operation 0 to 2 gives
// exactly one result beat on out_ch; operation code 3 is taken and discarded.
// The ring start and stop pages are written over the APB-style cfg_ port,
// register 0 at byte address 0 and register 1 at byte address 4; the user
// must write them only while the block is idle, which it does not enforce.
// An accepted item is written into the queue, and from the queue head the
// back end registers the result together with its read of the slot capacity
// memory, which feeds the size check on the output; a stalled result beat
// keeps the next item waiting in the queue.
// Throughput is one item per cycle while out_ch is not stalled, set by the single-item back end step.
// When the receiver stalls, the result beat holds, the two-entry queue fills
// and in_ch.ready drops once it is full.
// Reset empties the ring, sets the registers to pages 0x46 and 0xAA and the
// read page to 0x47; the capacity memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rx_buffer_ring_manager import rbrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rbrm_in_if.sink               in_ch,
  rbrm_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0]  start_page_r;
  logic [7:0]  stop_page_r;
  logic        cfg_wr;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  rbrm_entry_t q_entry;
  rbrm_qhead_t q_head;
  rbrm_cfg_t   cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_page_r <= RESET_START_PAGE;
      stop_page_r  <= RESET_STOP_PAGE;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_IDX_START) begin
        start_page_r <= cfg_pwdata[7:0];
      end else begin
        stop_page_r <= cfg_pwdata[7:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_STOP) ? CFG_DATA_W'(stop_page_r)
                                                     : CFG_DATA_W'(start_page_r);

  assign cfg.start_page = start_page_r;
  assign cfg.stop_page  = stop_page_r;

  rbrm_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  rbrm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  rbrm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
